[rtl/tdsn_pkg.sv]
// shared types, constants and helper functions for the torus site and neighbour map
package tdsn_pkg;

	localparam int DIMS = 4;
	localparam int GRID_W = 5;
	localparam int LOCAL_W = 7;
	localparam int SITE_W = 6;
	localparam int RANK_W = 16;
	localparam int GIDX_W = 40;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 7;
	localparam int QUEUE_DEPTH = 4;
	localparam int DIV_BITS = 4;
	localparam int DIV_STAGES_PER = RANK_W / DIV_BITS;
	localparam int DIV_STAGES = DIV_STAGES_PER * (DIMS - 1);
	localparam int XG_W = 12;
	localparam int DEF_MAX_GRID = 16;
	localparam int DEF_MAX_LOCAL = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_X  = 3'd0,
		REG_GRID_Y  = 3'd1,
		REG_GRID_Z  = 3'd2,
		REG_GRID_T  = 3'd3,
		REG_LOCAL_X = 3'd4,
		REG_LOCAL_Y = 3'd5,
		REG_LOCAL_Z = 3'd6,
		REG_LOCAL_T = 3'd7
	} cfg_reg_t;

	typedef enum logic {
		KIND_SITE      = 1'b0,
		KIND_NEIGHBOUR = 1'b1
	} kind_t;

	typedef struct packed {
		logic                kind;
		logic [RANK_W-1:0]   rank;
		logic [SITE_W-1:0]   site_x;
		logic [SITE_W-1:0]   site_y;
		logic [SITE_W-1:0]   site_z;
		logic [SITE_W-1:0]   site_t;
		logic [1:0]          direction;
		logic                forward;
	} req_t;

	typedef struct packed {
		logic [GIDX_W-1:0]   global_index;
		logic [RANK_W-1:0]   neighbour;
		logic                out_of_range;
	} rsp_t;

	typedef struct packed {
		logic [DIMS-1:0][GRID_W-1:0]  grid;
		logic [DIMS-1:0][LOCAL_W-1:0] lcl;
	} cfg_t;

	typedef struct packed {
		req_t item;
		logic site_bad;
	} fe_item_t;

	typedef struct packed {
		logic [GRID_W-1:0] r;
		logic [RANK_W-1:0] n;
	} div_t;

	function automatic logic [GRID_W-1:0] grid_eff(logic [GRID_W-1:0] v, int mx);
		logic [GRID_W-1:0] res;
		if (v == '0)
			res = GRID_W'(1);
		else if (int'(v) > mx)
			res = GRID_W'(mx);
		else
			res = v;
		return res;
	endfunction

	function automatic logic [LOCAL_W-1:0] local_eff(logic [LOCAL_W-1:0] v, int mx);
		logic [LOCAL_W-1:0] res;
		if (v == '0)
			res = LOCAL_W'(1);
		else if (int'(v) > mx)
			res = LOCAL_W'(mx);
		else
			res = v;
		return res;
	endfunction

	// restoring division, DIV_BITS (four) quotient bits per call
	function automatic div_t div_step(logic [GRID_W-1:0] r, logic [RANK_W-1:0] n,
			logic [GRID_W-1:0] d);
		logic [GRID_W:0]   t;
		logic [GRID_W-1:0] rr;
		logic [RANK_W-1:0] nn;
		div_t              res;
		rr = r;
		nn = n;
		for (int i = 0; i < DIV_BITS; i++) begin
			t = {rr, nn[RANK_W-1]};
			nn = {nn[RANK_W-2:0], 1'b0};
			if (t >= {1'b0, d}) begin
				t = t - {1'b0, d};
				nn[0] = 1'b1;
			end
			rr = t[GRID_W-1:0];
		end
		res.r = rr;
		res.n = nn;
		return res;
	endfunction

endpackage

[rtl/torus_domain_site_and_neighbour_map_unit.sv]
// top level of the torus site and neighbour map: configuration registers and the two halves
// One transaction in per cycle while req_stall is low, one result out per transaction, in order. A request is
// either a local site (kind 0), returned as its global lattice index, or a neighbour query
// (kind 1), returned as the rank one step along a direction with wrap-around. From
// acceptance to result an item passes one front-end register, the queue, twelve division
// steps that decode the rank into grid coordinates (four quotient bits per step), then
// five multiply-accumulate stages ending in the result register.
// Grid and local lengths of zero act as one and are capped at MAX_GRID and MAX_LOCAL.
// Write configuration only while no transaction is in flight.
module torus_domain_site_and_neighbour_map_unit #(
	parameter int MAX_GRID  = tdsn_pkg::DEF_MAX_GRID,
	parameter int MAX_LOCAL = tdsn_pkg::DEF_MAX_LOCAL
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  tdsn_pkg::req_t                      req,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output tdsn_pkg::rsp_t                      rsp,
	input  logic                                cfg_we,
	input  logic [tdsn_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tdsn_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import tdsn_pkg::*;

	cfg_t     cfg_q;
	logic     push;
	fe_item_t push_data;
	logic     q_full;
	logic     pop;
	fe_item_t head;
	logic     q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < DIMS; d++) begin
				cfg_q.grid[d] <= GRID_W'(1);
				cfg_q.lcl[d] <= LOCAL_W'(1);
			end
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_GRID_X:  cfg_q.grid[0] <= cfg_data[GRID_W-1:0];
				REG_GRID_Y:  cfg_q.grid[1] <= cfg_data[GRID_W-1:0];
				REG_GRID_Z:  cfg_q.grid[2] <= cfg_data[GRID_W-1:0];
				REG_GRID_T:  cfg_q.grid[3] <= cfg_data[GRID_W-1:0];
				REG_LOCAL_X: cfg_q.lcl[0] <= cfg_data[LOCAL_W-1:0];
				REG_LOCAL_Y: cfg_q.lcl[1] <= cfg_data[LOCAL_W-1:0];
				REG_LOCAL_Z: cfg_q.lcl[2] <= cfg_data[LOCAL_W-1:0];
				REG_LOCAL_T: cfg_q.lcl[3] <= cfg_data[LOCAL_W-1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	tdsn_front #(.MAX_LOCAL(MAX_LOCAL)) u_front (
		.clk, .arst_n, .req_valid, .req_stall, .req,
		.cfg(cfg_q), .push, .push_data, .q_full
	);

	tdsn_queue u_queue (
		.clk, .arst_n, .push, .push_data, .full(q_full),
		.pop, .head, .empty(q_empty)
	);

	tdsn_back #(.MAX_GRID(MAX_GRID), .MAX_LOCAL(MAX_LOCAL)) u_back (
		.clk, .arst_n, .cfg(cfg_q), .head, .q_empty, .pop,
		.rsp_valid, .rsp_stall, .rsp
	);

endmodule

[rtl/tdsn_front.sv]
// front end: takes transactions, flags bad site coordinates, feeds the queue
module tdsn_front #(
	parameter int MAX_LOCAL = tdsn_pkg::DEF_MAX_LOCAL
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  tdsn_pkg::req_t     req,
	input  tdsn_pkg::cfg_t     cfg,
	output logic               push,
	output tdsn_pkg::fe_item_t push_data,
	input  logic               q_full
);
	import tdsn_pkg::*;

	logic            v_s1;
	req_t            item_s1;
	logic            bad_s1;
	logic            accept;
	logic            site_bad;
	logic [DIMS-1:0][SITE_W-1:0] site;

	assign site = {req.site_t, req.site_z, req.site_y, req.site_x};

	always_comb begin
		site_bad = 1'b0;
		for (int d = 0; d < DIMS; d++) begin
			if ({1'b0, site[d]} >= local_eff(cfg.lcl[d], MAX_LOCAL))
				site_bad = 1'b1;
		end
		if (req.kind != KIND_SITE)
			site_bad = 1'b0;
	end

	assign push = v_s1 && !q_full;
	assign req_stall = v_s1 && q_full;
	assign accept = req_valid && !req_stall;
	assign push_data = '{item: item_s1, site_bad: bad_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= req;
			bad_s1 <= site_bad;
		end
	end

endmodule

[rtl/tdsn_queue.sv]
// short queue between front end and back end
module tdsn_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  tdsn_pkg::fe_item_t push_data,
	output logic               full,
	input  logic               pop,
	output tdsn_pkg::fe_item_t head,
	output logic               empty
);
	import tdsn_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	fe_item_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0]     wr_q;
	logic [PW-1:0]     rd_q;
	logic [PW:0]       cnt_q;

	assign full = (cnt_q == (PW+1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PW+1)'(QUEUE_DEPTH)) else $error("queue count overflow");
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty)) else $error("pop from empty queue");
	a_cnt_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("queue count slip");

endmodule

[rtl/tdsn_back.sv]
// back end: rank decode by pipelined division, index and neighbour arithmetic, result register
module tdsn_back #(
	parameter int MAX_GRID  = tdsn_pkg::DEF_MAX_GRID,
	parameter int MAX_LOCAL = tdsn_pkg::DEF_MAX_LOCAL
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tdsn_pkg::cfg_t     cfg,
	input  tdsn_pkg::fe_item_t head,
	input  logic               q_empty,
	output logic               pop,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output tdsn_pkg::rsp_t     rsp
);
	import tdsn_pkg::*;

	typedef struct packed {
		fe_item_t                    fe;
		logic [GRID_W-1:0]           r;
		logic [RANK_W-1:0]           n;
		logic [DIMS-1:0][GRID_W-1:0] crd;
	} dv_t;

	logic adv;
	logic [DIMS-1:0][GRID_W-1:0]  g;
	logic [DIMS-1:0][LOCAL_W-1:0] l;
	logic [DIMS-1:0][XG_W-1:0]    gl_q;
	logic [2*GRID_W-1:0]          t01_q;
	logic [2*GRID_W-1:0]          t23_q;
	logic [4*GRID_W-1:0]          total_q;

	dv_t  dv_s  [DIV_STAGES];
	logic dv_v_s [DIV_STAGES];

	always_comb begin
		for (int d = 0; d < DIMS; d++) begin
			g[d] = grid_eff(cfg.grid[d], MAX_GRID);
			l[d] = local_eff(cfg.lcl[d], MAX_LOCAL);
		end
	end

	// derived sizes, settled long before an item reaches them
	always_ff @(posedge clk) begin
		for (int d = 0; d < DIMS; d++)
			gl_q[d] <= XG_W'(g[d]) * XG_W'(l[d]);
		t01_q <= (2*GRID_W)'(g[0]) * (2*GRID_W)'(g[1]);
		t23_q <= (2*GRID_W)'(g[2]) * (2*GRID_W)'(g[3]);
		total_q <= (4*GRID_W)'(t01_q) * (4*GRID_W)'(t23_q);
	end

	assign adv = !rsp_valid || !rsp_stall;
	assign pop = adv && !q_empty;

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		localparam int J = k / DIV_STAGES_PER;
		dv_t  din;
		logic vin;
		div_t st;
		always_comb begin
			if (k == 0) begin
				din.fe = head;
				din.r = '0;
				din.n = head.item.rank;
				din.crd = '0;
				vin = !q_empty;
			end else begin
				din = dv_s[(k > 0) ? k-1 : 0];
				vin = dv_v_s[(k > 0) ? k-1 : 0];
				if ((k % DIV_STAGES_PER) == 0) begin
					din.crd[(J > 0) ? DIMS-J : 0] = din.r;
					din.r = '0;
				end
			end
			st = div_step(din.r, din.n, g[DIMS-1-J]);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_v_s[k] <= 1'b0;
			else if (adv)
				dv_v_s[k] <= vin;
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[k].fe <= din.fe;
				dv_s[k].crd <= din.crd;
				dv_s[k].r <= st.r;
				dv_s[k].n <= st.n;
			end
		end
	end

	// grid coordinates once decoding is done
	logic [DIMS-1:0][GRID_W-1:0] c;
	logic [DIMS-1:0][GRID_W-1:0] nc;
	logic [DIMS-1:0][SITE_W-1:0] s;
	req_t it;

	always_comb begin
		it = dv_s[DIV_STAGES-1].fe.item;
		c = dv_s[DIV_STAGES-1].crd;
		c[1] = dv_s[DIV_STAGES-1].r;
		c[0] = dv_s[DIV_STAGES-1].n[GRID_W-1:0];
		s = {it.site_t, it.site_z, it.site_y, it.site_x};
		nc = c;
		for (int d = 0; d < DIMS; d++) begin
			if (it.direction == 2'(d)) begin
				if (it.forward)
					nc[d] = (c[d] == g[d] - 1'b1) ? '0 : c[d] + 1'b1;
				else
					nc[d] = (c[d] == '0) ? g[d] - 1'b1 : c[d] - 1'b1;
			end
		end
	end

	logic                        m0_v_s, m1_v_s, m2_v_s, m3_v_s;
	logic                        m0_kind_s, m1_kind_s, m2_kind_s, m3_kind_s;
	logic                        m0_bad_s, m1_bad_s, m2_bad_s, m3_bad_s;
	logic [DIMS-1:0][XG_W-1:0]   m0_x_s;
	logic [DIMS-1:0][GRID_W-1:0] m0_nc_s;
	logic [2*XG_W-1:0]           m1_acc_s;
	logic [XG_W-1:0]             m1_x2_s, m1_x3_s, m2_x3_s, m3_x3_s;
	logic [9:0]                  m1_nb_s;
	logic [GRID_W-1:0]           m1_nc2_s, m1_nc3_s, m2_nc3_s;
	logic [3*XG_W-1:0]           m2_acc_s;
	logic [14:0]                 m2_nb_s;
	logic [31:0]                 m3_plo_s;
	logic [27:0]                 m3_phi_s;
	logic [4*GRID_W-1:0]         m3_nb_s;
	logic [GIDX_W-1:0]           gidx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m0_v_s <= 1'b0;
			m1_v_s <= 1'b0;
			m2_v_s <= 1'b0;
			m3_v_s <= 1'b0;
			rsp_valid <= 1'b0;
		end else if (adv) begin
			m0_v_s <= dv_v_s[DIV_STAGES-1];
			m1_v_s <= m0_v_s;
			m2_v_s <= m1_v_s;
			m3_v_s <= m2_v_s;
			rsp_valid <= m3_v_s;
		end
	end

	assign gidx = {m3_phi_s[19:0], 20'b0} + GIDX_W'(m3_plo_s) + GIDX_W'(m3_x3_s);

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int d = 0; d < DIMS; d++)
				m0_x_s[d] <= XG_W'(c[d]) * XG_W'(l[d]) + XG_W'(s[d]);
			m0_nc_s <= nc;
			m0_kind_s <= it.kind;
			m0_bad_s <= ((4*GRID_W)'(it.rank) >= total_q) || dv_s[DIV_STAGES-1].fe.site_bad;

			m1_acc_s <= (2*XG_W)'(m0_x_s[0]) * (2*XG_W)'(gl_q[1]) + (2*XG_W)'(m0_x_s[1]);
			m1_nb_s <= 10'(m0_nc_s[0]) * 10'(g[1]) + 10'(m0_nc_s[1]);
			m1_x2_s <= m0_x_s[2];
			m1_x3_s <= m0_x_s[3];
			m1_nc2_s <= m0_nc_s[2];
			m1_nc3_s <= m0_nc_s[3];
			m1_kind_s <= m0_kind_s;
			m1_bad_s <= m0_bad_s;

			m2_acc_s <= (3*XG_W)'(m1_acc_s) * (3*XG_W)'(gl_q[2]) + (3*XG_W)'(m1_x2_s);
			m2_nb_s <= 15'(m1_nb_s) * 15'(g[2]) + 15'(m1_nc2_s);
			m2_x3_s <= m1_x3_s;
			m2_nc3_s <= m1_nc3_s;
			m2_kind_s <= m1_kind_s;
			m2_bad_s <= m1_bad_s;

			m3_plo_s <= 32'(m2_acc_s[19:0]) * 32'(gl_q[3]);
			m3_phi_s <= 28'(m2_acc_s[35:20]) * 28'(gl_q[3]);
			m3_nb_s <= (4*GRID_W)'(m2_nb_s) * (4*GRID_W)'(g[3]) + (4*GRID_W)'(m2_nc3_s);
			m3_x3_s <= m2_x3_s;
			m3_kind_s <= m2_kind_s;
			m3_bad_s <= m2_bad_s;

			rsp.out_of_range <= m3_bad_s;
			rsp.global_index <= (m3_kind_s == KIND_SITE && !m3_bad_s) ? gidx : '0;
			rsp.neighbour <= (m3_kind_s == KIND_NEIGHBOUR && !m3_bad_s) ?
				m3_nb_s[RANK_W-1:0] : '0;
		end
	end

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.out_of_range |-> rsp.global_index == '0 && rsp.neighbour == '0)
		else $error("flagged result carries a value");
	a_one_field: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.global_index == '0 || rsp.neighbour == '0)
		else $error("both result fields set");
	a_nb_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.out_of_range |-> (4*GRID_W)'(rsp.neighbour) < total_q)
		else $error("neighbour outside grid");

endmodule
